// ===== design/mvsu_pkg.sv =====
// Shared constants and types for the mean/variance/std-dev unit.
`default_nettype none
package mvsu_pkg;
	localparam int CAPACITY = 1024;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam int SUMW = 16 + CW;
	localparam int MEANW = 24;
	localparam int VARW = 48;
	localparam int SDW = 24;
	localparam int SQW = 64;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;
	localparam logic [0:0] REG_SAMPLE_MODE = 1'd0;

	typedef struct packed {
		logic load;
		logic clear;
		logic div_start;
		logic pass_start;
		logic pass_step;
		logic vdiv_start;
		logic sqrt_start;
	} mvsu_cmd_t;

	typedef struct packed {
		logic div_done;
		logic pass_done;
		logic vdiv_done;
		logic sqrt_done;
		logic overflowed;
		logic divz;
	} mvsu_sts_t;
endpackage
`default_nettype wire

// ===== design/mvsu_datapath.sv =====
// Datapath: sample store, running sum, mean divider, deviation pass, variance divider, sqrt.
`default_nettype none
module mvsu_datapath (
	input  wire                       clk,
	input  wire                       arst_n,
	input  mvsu_pkg::mvsu_cmd_t       cmd,
	output mvsu_pkg::mvsu_sts_t       sts,
	input  wire  signed [15:0]        sample,
	input  wire                       sample_mode,
	output logic signed [23:0]        mean_out,
	output logic [47:0]               var_out,
	output logic [23:0]               sd_out,
	output logic [10:0]               count_out
);
	import mvsu_pkg::*;

	logic signed [15:0] mem [CAPACITY];
	logic [CW-1:0] count_q;
	logic signed [SUMW-1:0] sum_q;
	logic ovf_q;

	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CW'(CAPACITY))
			mem[count_q[AW-1:0]] <= sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			if (count_q < CW'(CAPACITY)) begin
				count_q <= count_q + 1'b1;
				sum_q <= sum_q + SUMW'(sample);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// mean: floor(|sum|*256 / n) restoring division, sign fixed at end
	localparam int NW = SUMW + 8;
	logic [NW-1:0] dq_q;
	logic [CW:0] drem_q;
	logic [5:0] dcnt_q;
	logic dbusy_q, dneg_q, ddone_q;
	logic signed [23:0] mean_q;
	logic [NW-1:0] abs_num;
	logic [CW:0] dtrial;
	logic signed [NW:0] qs;

	assign abs_num = sum_q[SUMW-1] ? NW'(-{sum_q, 8'd0}) : NW'({sum_q, 8'd0});
	assign dtrial = {drem_q[CW-1:0], dq_q[NW-1]};
	assign qs = dneg_q ? ((drem_q != '0) ? $signed(~{1'b0, dq_q})
		: -$signed({1'b0, dq_q})) : $signed({1'b0, dq_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dq_q <= abs_num;
				drem_q <= '0;
				dcnt_q <= 6'(NW);
				dneg_q <= sum_q[SUMW-1];
			end else if (dbusy_q) begin
				if (dcnt_q == '0) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
					mean_q <= qs[23:0];
				end else begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dtrial >= {1'b0, count_q}) begin
						drem_q <= dtrial - {1'b0, count_q};
						dq_q <= {dq_q[NW-2:0], 1'b1};
					end else begin
						drem_q <= dtrial;
						dq_q <= {dq_q[NW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// deviation pass: read, subtract, square, accumulate (pipelined)
	logic [CW-1:0] ridx_q;
	logic rvalid_s1, rvalid_s2, rvalid_s3;
	logic signed [15:0] rd_s1;
	logic signed [25:0] dev_s2;
	logic [49:0] sq_s3;
	logic [SQW-1:0] sq_sum_q;
	logic pdone_q;

	always_ff @(posedge clk) begin
		rd_s1 <= mem[ridx_q[AW-1:0]];
		dev_s2 <= 26'(rd_s1) * 26'sd256 - 26'(mean_q);
		sq_s3 <= 50'(dev_s2[25] ? -dev_s2 : dev_s2) * 50'(dev_s2[25] ? -dev_s2 : dev_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ridx_q <= '0;
			rvalid_s1 <= 1'b0;
			rvalid_s2 <= 1'b0;
			rvalid_s3 <= 1'b0;
			pdone_q <= 1'b0;
			sq_sum_q <= '0;
		end else begin
			pdone_q <= 1'b0;
			rvalid_s1 <= 1'b0;
			rvalid_s2 <= rvalid_s1;
			rvalid_s3 <= rvalid_s2;
			if (cmd.pass_start) begin
				ridx_q <= '0;
				sq_sum_q <= '0;
			end else if (cmd.pass_step) begin
				if (ridx_q < count_q) begin
					rvalid_s1 <= 1'b1;
					ridx_q <= ridx_q + 1'b1;
				end else if (!rvalid_s1 && !rvalid_s2 && !rvalid_s3) begin
					pdone_q <= 1'b1;
				end
			end
			if (rvalid_s3)
				sq_sum_q <= sq_sum_q + SQW'(sq_s3);
		end
	end

	// variance divide: sq_sum / divisor
	logic [SQW-1:0] vq_q;
	logic [CW:0] vrem_q;
	logic [6:0] vcnt_q;
	logic vbusy_q, vdone_q;
	logic [CW-1:0] divisor;
	logic [CW:0] vtrial;
	logic [47:0] var_q;

	assign divisor = sample_mode ? count_q - 1'b1 : count_q;
	assign vtrial = {vrem_q[CW-1:0], vq_q[SQW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbusy_q <= 1'b0;
			vdone_q <= 1'b0;
		end else begin
			vdone_q <= 1'b0;
			if (cmd.vdiv_start) begin
				vbusy_q <= 1'b1;
				vq_q <= sq_sum_q;
				vrem_q <= '0;
				vcnt_q <= 7'(SQW);
			end else if (vbusy_q) begin
				if (vcnt_q == '0) begin
					vbusy_q <= 1'b0;
					vdone_q <= 1'b1;
					var_q <= (vq_q[SQW-1:48] != '0) ? '1 : vq_q[47:0];
				end else begin
					vcnt_q <= vcnt_q - 1'b1;
					if (vtrial >= {1'b0, divisor}) begin
						vrem_q <= vtrial - {1'b0, divisor};
						vq_q <= {vq_q[SQW-2:0], 1'b1};
					end else begin
						vrem_q <= vtrial;
						vq_q <= {vq_q[SQW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// square root: two bits per step
	logic [47:0] srem_q;
	logic [23:0] sroot_q;
	logic [47:0] sv_q;
	logic [4:0] scnt_q;
	logic sbusy_q, sdone_q;
	logic [25:0] strial_rem;
	logic [25:0] strial_sub;

	assign strial_rem = {srem_q[23:0], sv_q[47:46]};
	assign strial_sub = {sroot_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			sdone_q <= 1'b0;
		end else begin
			sdone_q <= 1'b0;
			if (cmd.sqrt_start) begin
				sbusy_q <= 1'b1;
				srem_q <= '0;
				sroot_q <= '0;
				sv_q <= var_q;
				scnt_q <= 5'd24;
			end else if (sbusy_q) begin
				if (scnt_q == '0) begin
					sbusy_q <= 1'b0;
					sdone_q <= 1'b1;
				end else begin
					scnt_q <= scnt_q - 1'b1;
					sv_q <= {sv_q[45:0], 2'b00};
					if (strial_rem >= strial_sub) begin
						srem_q <= 48'(strial_rem - strial_sub);
						sroot_q <= {sroot_q[22:0], 1'b1};
					end else begin
						srem_q <= 48'(strial_rem);
						sroot_q <= {sroot_q[22:0], 1'b0};
					end
				end
			end
		end
	end

	assign mean_out = mean_q;
	assign var_out = var_q;
	assign sd_out = sroot_q;
	assign count_out = count_q;
	assign sts.div_done = ddone_q;
	assign sts.pass_done = pdone_q;
	assign sts.vdiv_done = vdone_q;
	assign sts.sqrt_done = sdone_q;
	assign sts.overflowed = ovf_q;
	assign sts.divz = sample_mode && (count_q <= CW'(1));
endmodule
`default_nettype wire

// ===== design/mvsu_ctrl.sv =====
// Controller state machine sequencing load, mean, pass, divide, sqrt and output.
`default_nettype none
module mvsu_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_last,
	output logic                 in_stall,
	input  mvsu_pkg::mvsu_sts_t  sts,
	output mvsu_pkg::mvsu_cmd_t  cmd,
	output logic                 capture,
	output logic [1:0]           cap_status,
	input  wire                  out_busy
);
	import mvsu_pkg::*;

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_MEAN = 3'd1;
	localparam logic [2:0] S_PASS = 3'd2;
	localparam logic [2:0] S_VDIV = 3'd3;
	localparam logic [2:0] S_SQRT = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;
	localparam logic [2:0] S_START = 3'd6;

	logic [2:0] state_q;
	logic acc;

	assign in_stall = (state_q != S_LOAD);
	assign acc = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		capture = 1'b0;
		cap_status = ST_OK;
		cmd.load = acc;
		unique case (state_q)
			S_LOAD: ;
			S_START: cmd.div_start = !sts.overflowed;
			S_MEAN: begin
				if (sts.overflowed) begin
					if (!out_busy) begin
						capture = 1'b1;
						cap_status = ST_OVF;
						cmd.clear = 1'b1;
					end
				end else if (sts.div_done) begin
					cmd.pass_start = 1'b1;
				end
			end
			S_PASS: begin
				cmd.pass_step = 1'b1;
				if (sts.pass_done && !sts.divz)
					cmd.vdiv_start = 1'b1;
			end
			S_VDIV: if (sts.vdiv_done) cmd.sqrt_start = 1'b1;
			S_SQRT: ;
			S_EMIT: begin
				if (!out_busy) begin
					capture = 1'b1;
					cap_status = sts.divz ? ST_DIVZ : ST_OK;
					cmd.clear = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: if (acc && in_last) state_q <= S_START;
				S_START: state_q <= S_MEAN;
				S_MEAN: begin
					if (sts.overflowed) begin
						if (!out_busy) state_q <= S_LOAD;
					end else if (sts.div_done) begin
						state_q <= S_PASS;
					end
				end
				S_PASS: if (sts.pass_done) state_q <= sts.divz ? S_EMIT : S_VDIV;
				S_VDIV: if (sts.vdiv_done) state_q <= S_SQRT;
				S_SQRT: if (sts.sqrt_done) state_q <= S_EMIT;
				S_EMIT: if (!out_busy) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/mean_variance_stddev_unit.sv =====
// Top level of the mean/variance/std-dev unit.
`default_nettype none
// Samples load one word per cycle, while in_stall is low, into a 1024-entry store.
// The word marked last closes the set: after a start state a restoring divider
// forms the mean, a pipelined pass over the store sums squared deviations, then
// the variance divider and the square root run (in sample mode a set of at most
// one sample skips those two); input stalls from the last word until capture.
// A result waits in the output register; the next set loads meanwhile only
// after that register is free at emit time. Overflowed sets skip the arithmetic.
module mean_variance_stddev_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [0:0]         paddr,
	input  wire  [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  signed [15:0] sample,
	input  wire                last,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [23:0] mean,
	output logic [47:0]        variance,
	output logic [23:0]        std_dev,
	output logic [10:0]        sample_count,
	output logic [1:0]         status
);
	import mvsu_pkg::*;

	mvsu_cmd_t cmd;
	mvsu_sts_t sts;
	logic mode_q;
	logic capture;
	logic [1:0] cap_status;
	logic signed [23:0] d_mean;
	logic [47:0] d_var;
	logic [23:0] d_sd;
	logic [10:0] d_cnt;
	logic ovf;

	assign pready = 1'b1;
	assign prdata = {31'd0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == REG_SAMPLE_MODE)
			mode_q <= pwdata[0];
	end

	mvsu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(last),
		.in_stall(in_stall), .sts(sts), .cmd(cmd), .capture(capture),
		.cap_status(cap_status), .out_busy(out_valid && out_stall)
	);

	mvsu_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .sample(sample),
		.sample_mode(mode_q), .mean_out(d_mean), .var_out(d_var),
		.sd_out(d_sd), .count_out(d_cnt)
	);

	assign ovf = (cap_status == ST_OVF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (capture)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			status <= cap_status;
			mean <= ovf ? '0 : d_mean;
			sample_count <= ovf ? '0 : d_cnt;
			variance <= (ovf || cap_status == ST_DIVZ) ? '0 : d_var;
			std_dev <= (ovf || cap_status == ST_DIVZ) ? '0 : d_sd;
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the mean/variance/std-dev unit: sets of samples, mode changes, stalls.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mvsu_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic signed [MEANW-1:0] mean_q8;
		logic [VARW-1:0] var_q16;
		logic [SDW-1:0] sd_q8;
		logic [10:0] count;
		logic [1:0] stat;
	} stats_word_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [0:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic signed [15:0] sample;
	logic last;
	logic out_valid, out_stall;
	logic signed [23:0] mean;
	logic [47:0] variance;
	logic [23:0] std_dev;
	logic [10:0] sample_count;
	logic [1:0] status;

	mean_variance_stddev_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.mean(mean), .variance(variance), .std_dev(std_dev),
		.sample_count(sample_count), .status(status)
	);

	stats_word_t expected_stats[$];
	shortint set_samples[$];
	longint set_sum;
	bit set_overflowed;
	bit mode_sample;
	int errors;
	int cycles;
	int items_sent;
	bit no_idle;
	int hold_off;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	task automatic close_set();
		stats_word_t w;
		longint n, m, q, d;
		longint unsigned ad, sq, vq, sd;
		if (set_overflowed) begin
			w.mean_q8 = '0; w.var_q16 = '0; w.sd_q8 = '0; w.count = '0; w.stat = ST_OVF;
		end else begin
			n = set_samples.size();
			q = (set_sum * 256) / n;
			if (((set_sum * 256) % n) != 0 && set_sum < 0) q -= 1;
			m = q;
			sq = 0;
			foreach (set_samples[i]) begin
				d = longint'(set_samples[i]) * 256 - m;
				ad = (d < 0) ? -d : d;
				sq += ad * ad;
			end
			vq = 0;
			sd = 0;
			w.stat = ST_OK;
			if (mode_sample && n <= 1) begin
				w.stat = ST_DIVZ;
			end else begin
				vq = sq / (mode_sample ? n - 1 : n);
				if (vq > 64'hFFFF_FFFF_FFFF) vq = 64'hFFFF_FFFF_FFFF;
				sd = int_sqrt(vq);
				if (sd > 64'hFF_FFFF) sd = 64'hFF_FFFF;
			end
			w.mean_q8 = m[23:0];
			w.var_q16 = vq[47:0];
			w.sd_q8 = sd[23:0];
			w.count = n[10:0];
		end
		expected_stats.push_back(w);
		set_samples.delete();
		set_sum = 0;
		set_overflowed = 0;
	endtask

	task automatic send_word(input logic signed [15:0] s, input bit l);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1;
		sample <= s;
		last <= l;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (set_samples.size() < CAPACITY) begin
			set_samples.push_back(s);
			set_sum += s;
		end else begin
			set_overflowed = 1;
		end
		if (l) close_set();
	endtask

	task automatic end_stream();
		in_valid <= 0;
	endtask

	task automatic wait_idle();
		end_stream();
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= REG_SAMPLE_MODE;
		pwdata <= {31'($urandom() >> 1), m};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		mode_sample = m;
	endtask

	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_stall <= 1;
			hold_off <= hold_off - 1;
		end else if (!no_idle && !out_stall && $urandom_range(0, 5) == 0) begin
			out_stall <= 1;
		end else if (out_stall && $urandom_range(0, 3) != 0 && !no_idle) begin
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch in %s: got %0d, expected %0d", field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		stats_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				w = expected_stats.pop_front();
				if (mean !== w.mean_q8) report_mismatch("mean", mean, w.mean_q8);
				if (variance !== w.var_q16) report_mismatch("variance", variance, w.var_q16);
				if (std_dev !== w.sd_q8) report_mismatch("std_dev", std_dev, w.sd_q8);
				if (sample_count !== w.count)
					report_mismatch("sample_count", sample_count, w.count);
				if (status !== w.stat) report_mismatch("status", status, w.stat);
			end
		end
	end

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++) send_word(pick_sample(), i == n - 1);
	endtask

	task automatic test_directed();
		send_word(16'sh8000, 1);
		send_word(16'sh7FFF, 0);
		send_word(16'sh8000, 1);
		send_word(-16'sd1, 0);
		send_word(-16'sd2, 0);
		send_word(16'sd0, 1);
		for (int i = 0; i < 4; i++) send_word(16'sh7FFF, i == 3);
		wait_idle();
		write_mode(1);
		send_word(16'sd5, 1);
		send_word(16'sh7FFF, 0);
		send_word(16'sh8000, 1);
		send_word(-16'sd3, 0);
		send_word(16'sd4, 0);
		send_word(16'sd7, 1);
		wait_idle();
		write_mode(0);
	endtask

	task automatic test_capacity();
		for (int i = 0; i < CAPACITY; i++) send_word(pick_sample(), i == CAPACITY - 1);
		for (int i = 0; i < CAPACITY + 2; i++) send_word(pick_sample(), i == CAPACITY + 1);
		wait_idle();
		write_mode(1);
		for (int i = 0; i < CAPACITY + 1; i++) send_word(16'sh8000, i == CAPACITY);
		wait_idle();
	endtask

	task automatic test_random(input int quota);
		int start;
		start = items_sent;
		while (items_sent - start < quota) begin
			if ($urandom_range(0, 5) == 0) begin
				wait_idle();
				write_mode(1'($urandom_range(0, 1)));
			end
			send_set(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
				: $urandom_range(1, 16));
		end
	endtask

	task automatic test_pressure();
		hold_off <= 400;
		for (int i = 0; i < 6; i++) send_set($urandom_range(1, 5));
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; sample = '0; last = 0; out_stall = 0;
		hold_off = 0; no_idle = 0; errors = 0; items_sent = 0;
		set_sum = 0; set_overflowed = 0; mode_sample = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_capacity();
		write_mode(0);
		test_random(200);
		test_pressure();
		test_random(100);
		wait_idle();
		no_idle = 1;
		write_mode(1);
		test_random(100);
		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_stats.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
